// File: hdl/cfoi_pkg.sv
`timescale 1ns / 1ps

package cfoi_pkg;

  localparam int WORD_W = 32;
  localparam int FRAC_W = 24;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_KICK = 2'd1;
  localparam logic [1:0] MODE_STEP = 2'd2;

  localparam logic [1:0] CFG_TIME_STEP  = 2'd0;
  localparam logic [1:0] CFG_FORCE_GAIN = 2'd1;
  localparam logic [1:0] CFG_INTEGRATOR = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  localparam logic [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam logic [4:0] PC_VERLET = 5'd0;
  localparam logic [4:0] PC_LEAP   = 5'd11;

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_MUL, ST_WB, ST_SQX, ST_SQY, ST_R2, ST_SQRT,
    ST_DLO, ST_DHI, ST_DEN, ST_NUM, ST_CHK, ST_DIV, ST_FIN
  } state_e;

  typedef enum logic [1:0] {UOP_MUL, UOP_ACC, UOP_END} uop_op_e;

  typedef enum logic [2:0] {
    OPD_VX, OPD_VY, OPD_AX0, OPD_AY0, OPD_T, OPD_SUMX, OPD_SUMY
  } opd_e;

  typedef enum logic [3:0] {
    DST_T, DST_SX, DST_SY, DST_PX, DST_PY, DST_PXS, DST_PYS, DST_VX, DST_VY
  } dst_e;

  typedef struct packed {
    uop_op_e op;
    opd_e    opd;
    logic    half;
    dst_e    dst;
    logic    slot;
  } uop_t;

  function automatic uop_t uop_rom(input logic [4:0] pc);
    uop_t u;
    u = '{UOP_END, OPD_VX, 1'b0, DST_T, 1'b0};
    case (pc)
      5'd0:  u = '{UOP_ACC, OPD_VX,   1'b0, DST_T,   1'b0};
      5'd1:  u = '{UOP_MUL, OPD_AX0,  1'b0, DST_T,   1'b0};
      5'd2:  u = '{UOP_MUL, OPD_VX,   1'b0, DST_SX,  1'b0};
      5'd3:  u = '{UOP_MUL, OPD_T,    1'b1, DST_PXS, 1'b0};
      5'd4:  u = '{UOP_MUL, OPD_AY0,  1'b0, DST_T,   1'b0};
      5'd5:  u = '{UOP_MUL, OPD_VY,   1'b0, DST_SY,  1'b0};
      5'd6:  u = '{UOP_MUL, OPD_T,    1'b1, DST_PYS, 1'b0};
      5'd7:  u = '{UOP_ACC, OPD_VX,   1'b0, DST_T,   1'b1};
      5'd8:  u = '{UOP_MUL, OPD_SUMX, 1'b1, DST_VX,  1'b0};
      5'd9:  u = '{UOP_MUL, OPD_SUMY, 1'b1, DST_VY,  1'b0};
      5'd11: u = '{UOP_MUL, OPD_VX,   1'b1, DST_PX,  1'b0};
      5'd12: u = '{UOP_MUL, OPD_VY,   1'b1, DST_PY,  1'b0};
      5'd13: u = '{UOP_ACC, OPD_VX,   1'b0, DST_T,   1'b0};
      5'd14: u = '{UOP_MUL, OPD_AX0,  1'b0, DST_VX,  1'b0};
      5'd15: u = '{UOP_MUL, OPD_AY0,  1'b0, DST_VY,  1'b0};
      5'd16: u = '{UOP_MUL, OPD_VX,   1'b1, DST_PX,  1'b0};
      5'd17: u = '{UOP_MUL, OPD_VY,   1'b1, DST_PY,  1'b0};
      default: u = '{UOP_END, OPD_VX, 1'b0, DST_T, 1'b0};
    endcase
    return u;
  endfunction

  // {saturated, word}
  function automatic logic [WORD_W:0] sat_word(input logic signed [41:0] v);
    logic [WORD_W:0] r;
    if (v > $signed({10'd0, WORD_MAX})) begin
      r = {1'b1, WORD_MAX};
    end else if (v < $signed({10'h3ff, WORD_MIN})) begin
      r = {1'b1, WORD_MIN};
    end else begin
      r = {1'b0, v[WORD_W-1:0]};
    end
    return r;
  endfunction

  // signed acceleration word from quotient magnitude
  function automatic logic [WORD_W:0] acc_word(input logic neg, input logic ovf,
                                               input logic [WORD_W-1:0] q);
    logic [WORD_W:0] r;
    if (ovf) begin
      r = {1'b1, neg ? WORD_MIN : WORD_MAX};
    end else if (neg) begin
      if (q > WORD_MIN) r = {1'b1, WORD_MIN};
      else r = {1'b0, WORD_W'(~q + 1'b1)};
    end else begin
      if (q[WORD_W-1]) r = {1'b1, WORD_MAX};
      else r = {1'b0, q};
    end
    return r;
  endfunction

endpackage

// File: hdl/central_force_orbit_integrator.sv
`timescale 1ns / 1ps
// Orbit integrator for one body in a 2-D inverse-square central field.
// Input channel (in_valid_i / in_stall_o) carries a mode and four Q8.24
// words: load the state, add a velocity impulse, or advance one step.
// Output channel (out_valid_o / out_stall_i) returns one request per input:
// the state after it and a status (ok, zero radius, saturated).
// Config port (cfg_we_i, cfg_idx_i, cfg_data_i) sets time step, force gain
// and Verlet or leapfrog; write it only while the block is idle.
// Load and impulse, and the unused mode, which only returns the state, go
// straight to the output stage. A step runs a micro-op list: each
// acceleration evaluation squares the radius, takes a 32-iteration square
// root and runs up to two 32-iteration divides, and each scaled product
// passes through fetch, multiply and write back.
// in_stall_o is high from acceptance until the result is handed to the
// output register, so one request is in work at a time.
// When the receiver stalls, the result waits in the output register; a
// finished request that finds it full holds the block until it drains.
// Reset clears the state to zero, sets time step 16777, force gain -1.0,
// Verlet, and leaves the output empty.
module central_force_orbit_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] first_x_i,
  input  logic signed [31:0] first_y_i,
  input  logic signed [31:0] second_x_i,
  input  logic signed [31:0] second_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_position_x_o,
  output logic signed [31:0] out_position_y_o,
  output logic signed [31:0] out_velocity_x_o,
  output logic signed [31:0] out_velocity_y_o,
  output logic [1:0]         status_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import cfoi_pkg::*;

  state_e state_q, state_d;
  logic [4:0] pc_q, pc_d;
  logic signed [31:0] px_q, px_d, py_q, py_d, vx_q, vx_d, vy_q, vy_d;
  logic signed [31:0] ax0_q, ax0_d, ay0_q, ay0_d, ax1_q, ax1_d, ay1_q, ay1_d;
  logic signed [31:0] t_q, t_d;
  logic signed [33:0] sum_q, sum_d;
  logic [63:0] r2_q, r2_d;
  logic [95:0] den_q, den_d;
  logic axis_q, axis_d;
  logic sf_q, sf_d, zf_q, zf_d;
  logic [30:0] dt_q;
  logic signed [31:0] k_q;
  logic integ_q;
  logic out_valid_q, out_valid_d;
  logic signed [31:0] opx_q, opx_d, opy_q, opy_d, ovx_q, ovx_d, ovy_q, ovy_d;
  logic [1:0] ost_q, ost_d;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic sqrt_start, sqrt_done;
  logic [31:0] root;
  logic div_start, div_done;
  logic [31:0] div_quo;

  uop_t uop;
  logic signed [32:0] opd_v;
  logic opd_neg;
  logic [32:0] opd_mag;
  logic [64:0] rnd_full;
  logic signed [41:0] term_mag, term_s;
  logic [32:0] term_sat, upd, kick_x, kick_y, ares;
  logic signed [31:0] term_w;
  logic [31:0] ux, uy, k_mag, c_mag;
  logic signed [31:0] cur_c;
  logic ax_neg;
  logic [95:0] rem0;
  logic ovf;
  logic [63:0] r2_sum;
  logic res_we;

  cfoi_mul u_mul (.clk_i(clk_i), .a_i(mul_a), .b_i(mul_b), .p_o(mul_p));

  cfoi_sqrt u_sqrt (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(sqrt_start), .value_i(r2_sum),
    .done_o(sqrt_done), .root_o(root)
  );

  cfoi_div u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start), .rem_i(rem0),
    .den_i(den_q), .done_o(div_done), .quo_o(div_quo)
  );

  assign uop = uop_rom(pc_q);

  always_comb begin
    case (uop.opd)
      OPD_VX:   opd_v = 33'(vx_q);
      OPD_VY:   opd_v = 33'(vy_q);
      OPD_AX0:  opd_v = 33'(ax0_q);
      OPD_AY0:  opd_v = 33'(ay0_q);
      OPD_T:    opd_v = 33'(t_q);
      OPD_SUMX: opd_v = 33'(ax0_q) + 33'(ax1_q);
      OPD_SUMY: opd_v = 33'(ay0_q) + 33'(ay1_q);
      default:  opd_v = '0;
    endcase
  end

  assign opd_neg  = opd_v[32];
  assign opd_mag  = opd_neg ? 33'(-opd_v) : 33'(opd_v);
  assign rnd_full = uop.half ? ((mul_p + (65'd1 << FRAC_W)) >> (FRAC_W + 1))
                             : ((mul_p + (65'd1 << (FRAC_W - 1))) >> FRAC_W);
  assign term_mag = $signed({1'b0, rnd_full[40:0]});
  assign term_s   = opd_neg ? -term_mag : term_mag;
  assign term_sat = sat_word(term_s);
  assign term_w   = $signed(term_sat[31:0]);

  assign kick_x = sat_word(42'(vx_q) + 42'(first_x_i));
  assign kick_y = sat_word(42'(vy_q) + 42'(first_y_i));

  assign ux     = px_q[31] ? (~px_q + 32'd1) : px_q;
  assign uy     = py_q[31] ? (~py_q + 32'd1) : py_q;
  assign k_mag  = k_q[31] ? (~k_q + 32'd1) : k_q;
  assign cur_c  = axis_q ? py_q : px_q;
  assign c_mag  = cur_c[31] ? (~cur_c + 32'd1) : cur_c;
  assign ax_neg = k_q[31] ^ cur_c[31];
  assign rem0   = {16'd0, mul_p[63:0], 16'd0};
  assign ovf    = rem0 >= den_q;
  assign r2_sum = r2_q + mul_p[63:0];

  always_comb begin
    state_d = state_q;
    pc_d = pc_q;
    px_d = px_q; py_d = py_q; vx_d = vx_q; vy_d = vy_q;
    ax0_d = ax0_q; ay0_d = ay0_q; ax1_d = ax1_q; ay1_d = ay1_q;
    t_d = t_q; sum_d = sum_q; r2_d = r2_q; den_d = den_q; axis_d = axis_q;
    sf_d = sf_q; zf_d = zf_q;
    out_valid_d = out_valid_q & out_stall_i;
    opx_d = opx_q; opy_d = opy_q; ovx_d = ovx_q; ovy_d = ovy_q; ost_d = ost_q;
    mul_a = '0; mul_b = '0;
    sqrt_start = 1'b0; div_start = 1'b0;
    upd = '0; ares = '0; res_we = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          sf_d = 1'b0;
          zf_d = 1'b0;
          state_d = ST_FIN;
          case (mode_i)
            MODE_LOAD: begin
              px_d = first_x_i; py_d = first_y_i;
              vx_d = second_x_i; vy_d = second_y_i;
            end
            MODE_KICK: begin
              vx_d = $signed(kick_x[31:0]);
              vy_d = $signed(kick_y[31:0]);
              sf_d = kick_x[32] | kick_y[32];
            end
            MODE_STEP: begin
              pc_d = integ_q ? PC_LEAP : PC_VERLET;
              state_d = ST_FETCH;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_FETCH: begin
        case (uop.op)
          UOP_MUL: state_d = ST_MUL;
          UOP_ACC: state_d = ST_SQX;
          default: state_d = ST_FIN;
        endcase
      end
      ST_MUL: begin
        mul_a = opd_mag;
        mul_b = {1'b0, dt_q};
        state_d = ST_WB;
      end
      ST_WB: begin
        case (uop.dst)
          DST_T:   t_d = term_w;
          DST_SX:  sum_d = 34'(px_q) + 34'(term_w);
          DST_SY:  sum_d = 34'(py_q) + 34'(term_w);
          DST_PX: begin
            upd = sat_word(42'(px_q) + 42'(term_w));
            px_d = $signed(upd[31:0]);
          end
          DST_PY: begin
            upd = sat_word(42'(py_q) + 42'(term_w));
            py_d = $signed(upd[31:0]);
          end
          DST_PXS: begin
            upd = sat_word(42'(sum_q) + 42'(term_w));
            px_d = $signed(upd[31:0]);
          end
          DST_PYS: begin
            upd = sat_word(42'(sum_q) + 42'(term_w));
            py_d = $signed(upd[31:0]);
          end
          DST_VX: begin
            upd = sat_word(42'(vx_q) + 42'(term_w));
            vx_d = $signed(upd[31:0]);
          end
          DST_VY: begin
            upd = sat_word(42'(vy_q) + 42'(term_w));
            vy_d = $signed(upd[31:0]);
          end
          default: ;
        endcase
        sf_d = sf_q | term_sat[32] | upd[32];
        pc_d = pc_q + 5'd1;
        state_d = ST_FETCH;
      end
      ST_SQX: begin
        mul_a = 33'(ux);
        mul_b = ux;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        r2_d = mul_p[63:0];
        mul_a = 33'(uy);
        mul_b = uy;
        state_d = ST_R2;
      end
      ST_R2: begin
        r2_d = r2_sum;
        if (r2_sum == 64'd0) begin
          zf_d = 1'b1;
          if (uop.slot) begin
            ax1_d = '0; ay1_d = '0;
          end else begin
            ax0_d = '0; ay0_d = '0;
          end
          pc_d = pc_q + 5'd1;
          state_d = ST_FETCH;
        end else begin
          sqrt_start = 1'b1;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqrt_done) state_d = ST_DLO;
      end
      ST_DLO: begin
        mul_a = {1'b0, r2_q[31:0]};
        mul_b = root;
        state_d = ST_DHI;
      end
      ST_DHI: begin
        den_d = {32'd0, mul_p[63:0]};
        mul_a = {1'b0, r2_q[63:32]};
        mul_b = root;
        state_d = ST_DEN;
      end
      ST_DEN: begin
        den_d = den_q + {mul_p[63:0], 32'd0};
        axis_d = 1'b0;
        state_d = ST_NUM;
      end
      ST_NUM: begin
        if ((k_q == 32'sd0) || (cur_c == 32'sd0)) begin
          res_we = 1'b1;
          ares = '0;
        end else begin
          mul_a = 33'(k_mag);
          mul_b = c_mag;
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (ovf) begin
          res_we = 1'b1;
          ares = acc_word(ax_neg, 1'b1, '0);
        end else begin
          div_start = 1'b1;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_we = 1'b1;
          ares = acc_word(ax_neg, 1'b0, div_quo);
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          opx_d = px_q; opy_d = py_q; ovx_d = vx_q; ovy_d = vy_q;
          ost_d = sf_q ? STAT_SAT : (zf_q ? STAT_ZERO : STAT_OK);
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (res_we) begin
      sf_d = sf_q | ares[32];
      case ({uop.slot, axis_q})
        2'b00:   ax0_d = $signed(ares[31:0]);
        2'b01:   ay0_d = $signed(ares[31:0]);
        2'b10:   ax1_d = $signed(ares[31:0]);
        default: ay1_d = $signed(ares[31:0]);
      endcase
      if (axis_q) begin
        pc_d = pc_q + 5'd1;
        state_d = ST_FETCH;
      end else begin
        axis_d = 1'b1;
        state_d = ST_NUM;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q <= '0;
      px_q <= '0; py_q <= '0; vx_q <= '0; vy_q <= '0;
      sf_q <= 1'b0; zf_q <= 1'b0;
      out_valid_q <= 1'b0;
      dt_q <= 31'd16777;
      k_q <= -(32'sd1 <<< FRAC_W);
      integ_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pc_q <= pc_d;
      px_q <= px_d; py_q <= py_d; vx_q <= vx_d; vy_q <= vy_d;
      sf_q <= sf_d; zf_q <= zf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIME_STEP:  dt_q <= cfg_data_i[30:0];
          CFG_FORCE_GAIN: k_q <= $signed(cfg_data_i);
          CFG_INTEGRATOR: integ_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ax0_q <= ax0_d; ay0_q <= ay0_d; ax1_q <= ax1_d; ay1_q <= ay1_d;
    t_q <= t_d; sum_q <= sum_d; r2_q <= r2_d; den_q <= den_d; axis_q <= axis_d;
    opx_q <= opx_d; opy_q <= opy_d; ovx_q <= ovx_d; ovy_q <= ovy_d;
    ost_q <= ost_d;
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_position_x_o = opx_q;
  assign out_position_y_o = opy_q;
  assign out_velocity_x_o = ovx_q;
  assign out_velocity_y_o = ovy_q;
  assign status_o         = ost_q;

endmodule

// File: hdl/cfoi_mul.sv
`timescale 1ns / 1ps

module cfoi_mul (
  input  logic        clk_i,
  input  logic [32:0] a_i,
  input  logic [31:0] b_i,
  output logic [64:0] p_o
);

  logic [64:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 65'(a_i) * 65'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: hdl/cfoi_sqrt.sv
`timescale 1ns / 1ps

module cfoi_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        run_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rem_q;
  logic [63:0] res_q;
  logic [63:0] bitv;
  logic [63:0] trial;

  assign bitv  = 64'd1 << {cnt_q, 1'b0};
  assign trial = res_q + bitv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == 5'd0);
      if (start_i) run_q <= 1'b1;
      else if (run_q && (cnt_q == 5'd0)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= value_i;
      res_q <= '0;
      cnt_q <= 5'd31;
    end else if (run_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bitv;
      end else begin
        res_q <= res_q >> 1;
      end
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[31:0];

endmodule

// File: hdl/cfoi_div.sv
`timescale 1ns / 1ps

module cfoi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [95:0] rem_i,
  input  logic [95:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);

  logic        run_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [95:0] rem_q;
  logic [95:0] den_q;
  logic [31:0] quo_q;
  logic [96:0] shifted;
  logic [96:0] diff;
  logic        ge;

  assign shifted = {rem_q, 1'b0};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= run_q && (cnt_q == 5'd0);
      if (start_i) run_q <= 1'b1;
      else if (run_q && (cnt_q == 5'd0)) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      den_q <= den_i;
      quo_q <= '0;
      cnt_q <= 5'd31;
    end else if (run_q) begin
      rem_q <= ge ? diff[95:0] : shifted[95:0];
      quo_q <= {quo_q[30:0], ge};
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
